// ===== design/macd_pkg.sv =====
package macd_pkg;

    localparam int PRICE_W     = 32;
    localparam int ALPHA_W     = 16;
    localparam int WARM_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int AVG_W       = PRICE_W + ALPHA_W;
    localparam int SIG_W       = AVG_W + 1;
    localparam int DIFF_W      = SIG_W + 1;
    localparam int OUT_W       = 33;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [ALPHA_W-1:0] ROUND_HALF = 16'h8000;

    localparam logic [ALPHA_W-1:0] FAST_ALPHA_RESET    = 16'd10082;
    localparam logic [ALPHA_W-1:0] SLOW_ALPHA_RESET    = 16'd4855;
    localparam logic [ALPHA_W-1:0] SIGNAL_ALPHA_RESET  = 16'd13107;
    localparam logic [WARM_W-1:0]  SLOW_WARMUP_RESET   = 8'd26;
    localparam logic [WARM_W-1:0]  SIGNAL_WARMUP_RESET = 8'd9;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_FAST_ALPHA,
        CFG_SLOW_ALPHA,
        CFG_SIGNAL_ALPHA,
        CFG_SLOW_WARMUP,
        CFG_SIGNAL_WARMUP
    } cfg_index_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FAST,
        ST_FAST_WAIT,
        ST_SLOW,
        ST_SLOW_WAIT,
        ST_MACD,
        ST_SIGNAL,
        ST_SIGNAL_WAIT,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        UNIT_IDLE,
        UNIT_LO,
        UNIT_HI,
        UNIT_SUM
    } unit_state_t;

    typedef struct packed {
        logic               start;
        logic [ALPHA_W-1:0] alpha;
    } step_req_t;

endpackage

// ===== design/macd_step_unit.sv =====
module macd_step_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  macd_pkg::step_req_t                 req,
    input  logic signed [macd_pkg::DIFF_W-1:0]  diff,
    output logic signed [macd_pkg::DIFF_W-1:0]  step,
    output logic                                done
);
    import macd_pkg::*;

    localparam int HI_W       = DIFF_W - ALPHA_W;
    localparam int PROD_W     = HI_W + ALPHA_W;
    localparam int LOW_PROD_W = 2 * ALPHA_W;
    localparam int ROUND_W    = ALPHA_W + 1;

    unit_state_t               state_reg, state_next;
    logic                      neg_reg, neg_next;
    logic [DIFF_W-1:0]         mag_reg, mag_next;
    logic [ALPHA_W-1:0]        alpha_reg, alpha_next;
    logic [PROD_W-1:0]         prod_reg, prod_next;
    logic [ROUND_W-1:0]        round_reg, round_next;
    logic signed [DIFF_W-1:0]  step_reg, step_next;
    logic                      done_reg, done_next;

    logic [HI_W-1:0]           mul_a;
    logic [PROD_W-1:0]         product;
    logic [LOW_PROD_W:0]       low_biased;
    logic [PROD_W-1:0]         total;

    // one multiplier: low half of the magnitude first, then the high half
    assign mul_a      = (state_reg == UNIT_LO) ? HI_W'(mag_reg[ALPHA_W-1:0])
                                               : mag_reg[DIFF_W-1:ALPHA_W];
    assign product    = PROD_W'(mul_a) * PROD_W'(alpha_reg);
    assign low_biased = (LOW_PROD_W+1)'(prod_reg[LOW_PROD_W-1:0])
                      + (LOW_PROD_W+1)'(ROUND_HALF);
    assign total      = prod_reg + PROD_W'(round_reg);

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        mag_next   = mag_reg;
        alpha_next = alpha_reg;
        prod_next  = prod_reg;
        round_next = round_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            UNIT_IDLE:
            begin
                if (req.start)
                begin
                    neg_next   = diff[DIFF_W-1];
                    mag_next   = diff[DIFF_W-1] ? $unsigned(-diff) : $unsigned(diff);
                    alpha_next = req.alpha;
                    state_next = UNIT_LO;
                end
            end
            UNIT_LO:
            begin
                prod_next  = product;
                state_next = UNIT_HI;
            end
            UNIT_HI:
            begin
                round_next = low_biased[LOW_PROD_W:ALPHA_W];
                prod_next  = product;
                state_next = UNIT_SUM;
            end
            UNIT_SUM:
            begin
                // magnitude was scaled, sign goes back on here
                step_next  = neg_reg ? -$signed(total) : $signed(total);
                done_next  = 1'b1;
                state_next = UNIT_IDLE;
            end
            default:
            begin
                state_next = UNIT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= UNIT_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg   <= neg_next;
        mag_reg   <= mag_next;
        alpha_reg <= alpha_next;
        prod_reg  <= prod_next;
        round_reg <= round_next;
        step_reg  <= step_next;
    end

    assign step = step_reg;
    assign done = done_reg;

    a_done_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        req.start && state_reg == UNIT_IDLE |-> ##4 done)
        else $error("step unit did not finish four cycles after start");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("step unit done held for more than one cycle");

endmodule

// ===== design/macd_indicator_stream_core.sv =====
// MACD indicator over a stream of closing prices (unsigned Q16.16, one per bar). Fast and
// slow exponential averages are kept at 32 fraction bits and seeded with the first price of
// a series (first bar after reset or a bar with start_series set); the signal line averages
// the valid MACD values. Each bar produces one result transaction. Every average update
// is a request state followed by a pass through the shared 34x16 multiply-and-round unit;
// a bar that seeds the averages skips the fast and slow updates. Each bar also passes
// through entry, MACD and the output register, and when the signal line is skipped or
// seeded, through a state that decides so.
// in_ready is high only between bars; a finished result waits in the output register, so
// the next bar is taken while it is still held. Configuration writes are always accepted
// and must only be issued while no bar is in progress.
module macd_indicator_stream_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [macd_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [macd_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [macd_pkg::PRICE_W-1:0]         price,
    input  logic                                 start_series,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic signed [macd_pkg::OUT_W-1:0]    macd_value,
    output logic signed [macd_pkg::OUT_W-1:0]    signal_value,
    output logic                                 macd_valid,
    output logic                                 signal_valid
);
    import macd_pkg::*;

    localparam int RND_W = SIG_W + 1;
    localparam int SHR_W = RND_W - ALPHA_W;
    localparam logic signed [RND_W-1:0] BIAS_POS = RND_W'(ROUND_HALF);
    localparam logic signed [RND_W-1:0] BIAS_NEG = RND_W'(ROUND_HALF) - RND_W'(1);
    localparam logic signed [SHR_W-1:0] OUT_HI   = SHR_W'(64'sd4294967295);
    localparam logic signed [SHR_W-1:0] OUT_LO   = -SHR_W'(64'sd4294967296);

    // Q.32 to Q16.16, rounded half away from zero, saturated
    function automatic logic [OUT_W-1:0] to_output(input logic signed [SIG_W-1:0] v);
        logic signed [RND_W-1:0] biased;
        logic signed [SHR_W-1:0] r;
        biased = RND_W'(v) + (v[SIG_W-1] ? BIAS_NEG : BIAS_POS);
        r      = $signed(biased[RND_W-1:ALPHA_W]);
        if (r > OUT_HI)
            return OUT_W'(OUT_HI);
        else if (r < OUT_LO)
            return OUT_W'(OUT_LO);
        else
            return r[OUT_W-1:0];
    endfunction

    state_t                    state_reg, state_next;
    logic [AVG_W-1:0]          x_reg, x_next;
    logic [AVG_W-1:0]          fast_reg, fast_next;
    logic [AVG_W-1:0]          slow_reg, slow_next;
    logic signed [SIG_W-1:0]   signal_reg, signal_next;
    logic signed [SIG_W-1:0]   macd_reg, macd_next;
    logic                      mvalid_reg, mvalid_next;
    logic [COUNT_W-1:0]        sample_count_reg, sample_count_next;
    logic [COUNT_W-1:0]        macd_count_reg, macd_count_next;

    logic [ALPHA_W-1:0]        fast_alpha_reg, fast_alpha_next;
    logic [ALPHA_W-1:0]        slow_alpha_reg, slow_alpha_next;
    logic [ALPHA_W-1:0]        signal_alpha_reg, signal_alpha_next;
    logic [WARM_W-1:0]         slow_warmup_reg, slow_warmup_next;
    logic [WARM_W-1:0]         signal_warmup_reg, signal_warmup_next;

    logic                      out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]          macd_value_reg, macd_value_next;
    logic [OUT_W-1:0]          signal_value_reg, signal_value_next;
    logic                      macd_valid_reg, macd_valid_next;
    logic                      signal_valid_reg, signal_valid_next;

    step_req_t                 unit_req;
    logic signed [DIFF_W-1:0]  unit_diff;
    logic signed [DIFF_W-1:0]  unit_step;
    logic                      unit_done;

    logic [AVG_W-1:0]          price_q;
    logic signed [DIFF_W-1:0]  x_ext, fast_ext, slow_ext, signal_ext, macd_ext;
    logic signed [DIFF_W-1:0]  fast_sum, slow_sum, signal_sum;
    logic                      svalid;

    assign price_q    = {price, ALPHA_W'(0)};
    assign x_ext      = $signed(DIFF_W'(x_reg));
    assign fast_ext   = $signed(DIFF_W'(fast_reg));
    assign slow_ext   = $signed(DIFF_W'(slow_reg));
    assign signal_ext = DIFF_W'(signal_reg);
    assign macd_ext   = DIFF_W'(macd_reg);
    assign fast_sum   = fast_ext + unit_step;
    assign slow_sum   = slow_ext + unit_step;
    assign signal_sum = signal_ext + unit_step;
    assign svalid     = mvalid_reg && (macd_count_reg >= signal_warmup_reg);

    assign cfg_ready  = 1'b1;
    assign in_ready   = (state_reg == ST_IDLE);

    macd_step_unit u_step (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (unit_req),
        .diff  (unit_diff),
        .step  (unit_step),
        .done  (unit_done)
    );

    always_comb
    begin
        state_next         = state_reg;
        x_next             = x_reg;
        fast_next          = fast_reg;
        slow_next          = slow_reg;
        signal_next        = signal_reg;
        macd_next          = macd_reg;
        mvalid_next        = mvalid_reg;
        sample_count_next  = sample_count_reg;
        macd_count_next    = macd_count_reg;
        fast_alpha_next    = fast_alpha_reg;
        slow_alpha_next    = slow_alpha_reg;
        signal_alpha_next  = signal_alpha_reg;
        slow_warmup_next   = slow_warmup_reg;
        signal_warmup_next = signal_warmup_reg;
        out_valid_next     = out_valid_reg;
        macd_value_next    = macd_value_reg;
        signal_value_next  = signal_value_reg;
        macd_valid_next    = macd_valid_reg;
        signal_valid_next  = signal_valid_reg;
        unit_req.start     = 1'b0;
        unit_req.alpha     = fast_alpha_reg;
        unit_diff          = '0;

        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_FAST_ALPHA:    fast_alpha_next    = cfg_data;
                CFG_SLOW_ALPHA:    slow_alpha_next    = cfg_data;
                CFG_SIGNAL_ALPHA:  signal_alpha_next  = cfg_data;
                CFG_SLOW_WARMUP:   slow_warmup_next   = cfg_data[WARM_W-1:0];
                CFG_SIGNAL_WARMUP: signal_warmup_next = cfg_data[WARM_W-1:0];
                default:           ;
            endcase
        end

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    x_next = price_q;
                    if (start_series || sample_count_reg == '0)
                    begin
                        fast_next         = price_q;
                        slow_next         = price_q;
                        signal_next       = '0;
                        sample_count_next = COUNT_W'(1);
                        macd_count_next   = '0;
                        state_next        = ST_MACD;
                    end
                    else
                    begin
                        state_next = ST_FAST;
                    end
                end
            end
            ST_FAST:
            begin
                unit_req.start = 1'b1;
                unit_req.alpha = fast_alpha_reg;
                unit_diff      = x_ext - fast_ext;
                state_next     = ST_FAST_WAIT;
            end
            ST_FAST_WAIT:
            begin
                if (unit_done)
                begin
                    fast_next  = fast_sum[AVG_W-1:0];
                    state_next = ST_SLOW;
                end
            end
            ST_SLOW:
            begin
                unit_req.start = 1'b1;
                unit_req.alpha = slow_alpha_reg;
                unit_diff      = x_ext - slow_ext;
                state_next     = ST_SLOW_WAIT;
            end
            ST_SLOW_WAIT:
            begin
                if (unit_done)
                begin
                    slow_next = slow_sum[AVG_W-1:0];
                    if (sample_count_reg != COUNT_MAX)
                        sample_count_next = sample_count_reg + COUNT_W'(1);
                    state_next = ST_MACD;
                end
            end
            ST_MACD:
            begin
                macd_next   = $signed(SIG_W'(fast_reg)) - $signed(SIG_W'(slow_reg));
                mvalid_next = (sample_count_reg >= slow_warmup_reg);
                state_next  = ST_SIGNAL;
            end
            ST_SIGNAL:
            begin
                if (!mvalid_reg)
                begin
                    state_next = ST_OUT;
                end
                else if (macd_count_reg == '0)
                begin
                    // first valid macd seeds the signal line
                    signal_next     = macd_reg;
                    macd_count_next = COUNT_W'(1);
                    state_next      = ST_OUT;
                end
                else
                begin
                    unit_req.start = 1'b1;
                    unit_req.alpha = signal_alpha_reg;
                    unit_diff      = macd_ext - signal_ext;
                    state_next     = ST_SIGNAL_WAIT;
                end
            end
            ST_SIGNAL_WAIT:
            begin
                if (unit_done)
                begin
                    signal_next = $signed(signal_sum[SIG_W-1:0]);
                    if (macd_count_reg != COUNT_MAX)
                        macd_count_next = macd_count_reg + COUNT_W'(1);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                // wait here only while the previous result is still held
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    macd_valid_next   = mvalid_reg;
                    signal_valid_next = svalid;
                    macd_value_next   = mvalid_reg ? to_output(macd_reg) : '0;
                    signal_value_next = svalid ? to_output(signal_reg) : '0;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            sample_count_reg  <= '0;
            macd_count_reg    <= '0;
            mvalid_reg        <= 1'b0;
            fast_alpha_reg    <= FAST_ALPHA_RESET;
            slow_alpha_reg    <= SLOW_ALPHA_RESET;
            signal_alpha_reg  <= SIGNAL_ALPHA_RESET;
            slow_warmup_reg   <= SLOW_WARMUP_RESET;
            signal_warmup_reg <= SIGNAL_WARMUP_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            sample_count_reg  <= sample_count_next;
            macd_count_reg    <= macd_count_next;
            mvalid_reg        <= mvalid_next;
            fast_alpha_reg    <= fast_alpha_next;
            slow_alpha_reg    <= slow_alpha_next;
            signal_alpha_reg  <= signal_alpha_next;
            slow_warmup_reg   <= slow_warmup_next;
            signal_warmup_reg <= signal_warmup_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg            <= x_next;
        fast_reg         <= fast_next;
        slow_reg         <= slow_next;
        signal_reg       <= signal_next;
        macd_reg         <= macd_next;
        macd_value_reg   <= macd_value_next;
        signal_value_reg <= signal_value_next;
        macd_valid_reg   <= macd_valid_next;
        signal_valid_reg <= signal_valid_next;
    end

    assign out_valid    = out_valid_reg;
    assign macd_value   = $signed(macd_value_reg);
    assign signal_value = $signed(signal_value_reg);
    assign macd_valid   = macd_valid_reg;
    assign signal_valid = signal_valid_reg;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken again right after a transaction");

    a_signal_needs_macd: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (macd_valid || !signal_valid))
        else $error("signal line valid without valid macd");

    a_invalid_macd_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !macd_valid |-> (macd_value == '0 && signal_value == '0))
        else $error("nonzero value reported during warm-up");

endmodule
